// File: rtl/qoe_pkg.sv
`timescale 1ns / 1ps
package qoe_pkg;

   localparam int COLOR_W       = 16;
   localparam int INDEX_ENTRIES = 64;
   localparam int HASH_W        = $clog2(INDEX_ENTRIES);
   localparam int RUN_W         = 17;
   localparam int LEN_W         = 32;
   localparam int CMDQ_DEPTH_DEF = 4;

   localparam logic [RUN_W-1:0] RUN_CAP       = 17'h10000;
   localparam logic [RUN_W-1:0] SHORT_RUN_MAX = 17'd64;
   localparam logic [LEN_W-1:0] HDR_BYTES     = 32'd8;
   localparam logic [LEN_W-1:0] MIN_FRAME_HDR = 32'd8;

   localparam logic [7:0] OP_RUN      = 8'h80;
   localparam logic [7:0] OP_LONG_RUN = 8'hFD;
   localparam logic [7:0] OP_RAW      = 8'hFF;

   localparam logic [7:0] MAGIC0 = 8'h43;
   localparam logic [7:0] MAGIC1 = 8'h50;
   localparam logic [7:0] MAGIC2 = 8'h51;
   localparam logic [7:0] MAGIC3 = 8'h4F;

   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CAPACITY = 2'd2;

   // output byte slots of one command, in emission order
   localparam int SLOT_N = 15;
   localparam int SLOT_W = $clog2(SLOT_N);
   localparam logic [SLOT_W-1:0] SLOT_MAGIC0    = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_MAGIC1    = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_MAGIC2    = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_MAGIC3    = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_WIDTH_LO  = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_WIDTH_HI  = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_HEIGHT_LO = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_HEIGHT_HI = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_RUN_OP    = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_RUN_LO    = 4'd9;
   localparam logic [SLOT_W-1:0] SLOT_RUN_HI    = 4'd10;
   localparam logic [SLOT_W-1:0] SLOT_TOK_OP    = 4'd11;
   localparam logic [SLOT_W-1:0] SLOT_COLOR_LO  = 4'd12;
   localparam logic [SLOT_W-1:0] SLOT_COLOR_HI  = 4'd13;
   localparam logic [SLOT_W-1:0] SLOT_OVERFLOW  = 4'd14;

   typedef struct packed {
      logic               hdr;
      logic               flush;
      logic               flush_long;
      logic [15:0]        run_m1;
      logic               tok;
      logic               tok_raw;
      logic [COLOR_W-1:0] color;
      logic               ovf;
      logic               frame_end;
      logic [LEN_W-1:0]   len;
   } cmd_type;

   function automatic logic [HASH_W-1:0] hash_color(input logic [COLOR_W-1:0] c);
      hash_color = HASH_W'(c ^ (c >> 5) ^ (c >> 11));
   endfunction

endpackage

// File: rtl/qoe_ram.sv
`timescale 1ns / 1ps
module qoe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/qoe_front.sv
`timescale 1ns / 1ps
module qoe_front import qoe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [COLOR_W-1:0] req_pixel_color,
   input  logic [LEN_W-1:0]   capacity,
   input  logic [LEN_W-1:0]   total,
   output logic               cmd_push,
   output cmd_type            cmd_data,
   input  logic               cmd_full
);

   logic               stg_valid_ff;
   logic [COLOR_W-1:0] stg_color_ff;
   logic [HASH_W-1:0]  stg_hash_ff;
   logic [COLOR_W-1:0] prev_color_ff, prev_color_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [LEN_W-1:0]   seen_ff, seen_in;
   logic [LEN_W-1:0]   written_ff, written_in;
   logic               dropped_ff, dropped_in;
   logic [INDEX_ENTRIES-1:0] valid_ff;
   logic               fwd_valid_ff;
   logic [HASH_W-1:0]  fwd_hash_ff;
   logic [COLOR_W-1:0] fwd_data_ff;

   logic               accept, fire, idx_wr;
   logic [COLOR_W-1:0] ram_rdata;

   logic               frame_start, last, active, equal, hit, hdr_ovf;
   logic               flush_do, flush_ovf, tok_ovf;
   logic [COLOR_W-1:0] prev, entry;
   logic [RUN_W-1:0]   run, run_inc, flush_len, run_m1;
   logic [LEN_W-1:0]   pre;
   logic [1:0]         n_f, n_t;
   logic [LEN_W:0]     sum1, sum2, cap_x;
   cmd_type            c;

   assign fire     = stg_valid_ff && !cmd_full;
   assign req_full = stg_valid_ff && cmd_full;
   assign accept   = req_push && !req_full;

   qoe_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (INDEX_ENTRIES)
   ) u_index (
      .clock (clock),
      .we    (fire && idx_wr),
      .waddr (stg_hash_ff),
      .wdata (stg_color_ff),
      .re    (accept),
      .raddr (hash_color(req_pixel_color)),
      .rdata (ram_rdata)
   );

   always_comb begin
      frame_start = (seen_ff == '0);
      prev        = frame_start ? '0 : prev_color_ff;
      run         = frame_start ? '0 : run_ff;
      last        = ({1'b0, seen_ff} + (LEN_W+1)'(1)) >= {1'b0, total};
      cap_x       = {1'b0, capacity};
      hdr_ovf     = frame_start && (capacity < MIN_FRAME_HDR);
      active      = frame_start ? !hdr_ovf : !dropped_ff;
      pre         = frame_start ? HDR_BYTES : written_ff;
      equal       = (stg_color_ff == prev);
      run_inc     = run + RUN_W'(1);

      // same-edge write to this slot is not yet in the registered read data
      if (fwd_valid_ff && fwd_hash_ff == stg_hash_ff) begin
         entry = fwd_data_ff;
      end else begin
         entry = ram_rdata;
      end
      if (frame_start || !valid_ff[stg_hash_ff]) begin
         entry = '0;
      end
      hit = (entry == stg_color_ff);

      if (equal) begin
         flush_do  = (run_inc == RUN_CAP) || last;
         flush_len = run_inc;
      end else begin
         flush_do  = (run != '0);
         flush_len = run;
      end
      run_m1 = flush_len - RUN_W'(1);
      n_f    = !flush_do ? 2'd0 : ((flush_len <= SHORT_RUN_MAX) ? 2'd1 : 2'd3);
      n_t    = hit ? 2'd1 : 2'd3;
      sum1   = {1'b0, pre} + (LEN_W+1)'(n_f);
      sum2   = {1'b0, pre} + (LEN_W+1)'({1'b0, n_f} + {1'b0, n_t});

      flush_ovf = active && flush_do && (sum1 > cap_x);
      tok_ovf   = active && !equal && !flush_ovf && (sum2 > cap_x);

      c            = '0;
      c.hdr        = frame_start && !hdr_ovf;
      c.flush      = active && flush_do && !flush_ovf;
      c.flush_long = (n_f == 2'd3);
      c.run_m1     = run_m1[15:0];
      c.tok        = active && !equal && !flush_ovf && !tok_ovf;
      c.tok_raw    = !hit;
      c.color      = stg_color_ff;
      c.ovf        = hdr_ovf || flush_ovf || tok_ovf;
      idx_wr       = c.tok && !hit;

      if (!active) begin
         written_in = frame_start ? '0 : written_ff;
      end else if (flush_ovf) begin
         written_in = pre;
      end else if (c.tok) begin
         written_in = sum2[LEN_W-1:0];
      end else begin
         written_in = sum1[LEN_W-1:0];
      end
      dropped_in  = !active || flush_ovf || tok_ovf;
      c.frame_end = last && !dropped_in;
      c.len       = written_in;

      seen_in       = last ? '0 : seen_ff + LEN_W'(1);
      prev_color_in = (active && !equal && !flush_ovf) ? stg_color_ff : prev;
      if (!active) begin
         run_in = run;
      end else if (equal && !flush_do) begin
         run_in = run_inc;
      end else begin
         run_in = '0;
      end
   end

   assign cmd_push = fire && (c.hdr || c.flush || c.tok || c.ovf);
   assign cmd_data = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         prev_color_ff <= '0;
         run_ff        <= '0;
         seen_ff       <= '0;
         written_ff    <= '0;
         dropped_ff    <= 1'b0;
         valid_ff      <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            stg_valid_ff <= 1'b1;
            fwd_valid_ff <= fire && idx_wr;
         end else if (fire) begin
            stg_valid_ff <= 1'b0;
         end
         if (fire) begin
            prev_color_ff <= prev_color_in;
            run_ff        <= run_in;
            seen_ff       <= seen_in;
            written_ff    <= written_in;
            dropped_ff    <= dropped_in;
            if (frame_start) begin
               valid_ff <= idx_wr ? (INDEX_ENTRIES'(1) << stg_hash_ff) : '0;
            end else if (idx_wr) begin
               valid_ff[stg_hash_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_color_ff <= req_pixel_color;
         stg_hash_ff  <= hash_color(req_pixel_color);
         fwd_hash_ff  <= stg_hash_ff;
         fwd_data_ff  <= stg_color_ff;
      end
   end

endmodule

// File: rtl/qoe_cmdq.sv
`timescale 1ns / 1ps
module qoe_cmdq import qoe_pkg::*; #(
   parameter int DEPTH = CMDQ_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full  = (count_ff == CNT_FULL);
   assign valid = (count_ff != '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/qoe_back.sv
`timescale 1ns / 1ps
module qoe_back import qoe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   input  logic [15:0]      image_width,
   input  logic [15:0]      image_height,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_item_last,
   output logic             rsp_frame_end,
   output logic             rsp_overflow,
   output logic [LEN_W-1:0] rsp_encoded_length
);

   logic [SLOT_N-1:0] done_ff, done_in;
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              item_last_ff, frame_end_ff, overflow_ff;
   logic [LEN_W-1:0]  length_ff;

   logic [SLOT_N-1:0] en, rem, low;
   logic [SLOT_W-1:0] slot;
   logic              is_last, emit;

   always_comb begin
      en                 = '0;
      en[SLOT_MAGIC0]    = cmd.hdr;
      en[SLOT_MAGIC1]    = cmd.hdr;
      en[SLOT_MAGIC2]    = cmd.hdr;
      en[SLOT_MAGIC3]    = cmd.hdr;
      en[SLOT_WIDTH_LO]  = cmd.hdr;
      en[SLOT_WIDTH_HI]  = cmd.hdr;
      en[SLOT_HEIGHT_LO] = cmd.hdr;
      en[SLOT_HEIGHT_HI] = cmd.hdr;
      en[SLOT_RUN_OP]    = cmd.flush;
      en[SLOT_RUN_LO]    = cmd.flush && cmd.flush_long;
      en[SLOT_RUN_HI]    = cmd.flush && cmd.flush_long;
      en[SLOT_TOK_OP]    = cmd.tok;
      en[SLOT_COLOR_LO]  = cmd.tok && cmd.tok_raw;
      en[SLOT_COLOR_HI]  = cmd.tok && cmd.tok_raw;
      en[SLOT_OVERFLOW]  = cmd.ovf;

      rem     = en & ~done_ff;
      low     = rem & SLOT_N'(~rem + SLOT_N'(1));
      is_last = ((rem & ~low) == '0);
      slot    = '0;
      for (int i = 0; i < SLOT_N; i++) begin
         if (low[i]) begin
            slot = slot | SLOT_W'(i);
         end
      end

      case (slot)
         SLOT_MAGIC0:    out_byte_in = MAGIC0;
         SLOT_MAGIC1:    out_byte_in = MAGIC1;
         SLOT_MAGIC2:    out_byte_in = MAGIC2;
         SLOT_MAGIC3:    out_byte_in = MAGIC3;
         SLOT_WIDTH_LO:  out_byte_in = image_width[7:0];
         SLOT_WIDTH_HI:  out_byte_in = image_width[15:8];
         SLOT_HEIGHT_LO: out_byte_in = image_height[7:0];
         SLOT_HEIGHT_HI: out_byte_in = image_height[15:8];
         SLOT_RUN_OP:    out_byte_in = cmd.flush_long ? OP_LONG_RUN
                                                      : (OP_RUN | {2'b00, cmd.run_m1[5:0]});
         SLOT_RUN_LO:    out_byte_in = cmd.run_m1[7:0];
         SLOT_RUN_HI:    out_byte_in = cmd.run_m1[15:8];
         SLOT_TOK_OP:    out_byte_in = cmd.tok_raw ? OP_RAW
                                                   : 8'(hash_color(cmd.color));
         SLOT_COLOR_LO:  out_byte_in = cmd.color[7:0];
         SLOT_COLOR_HI:  out_byte_in = cmd.color[15:8];
         default:        out_byte_in = '0;
      endcase

      emit    = cmd_valid && (!out_valid_ff || rsp_pop);
      done_in = is_last ? '0 : (done_ff | low);
   end

   assign cmd_pop = emit && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            done_ff      <= done_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= out_byte_in;
         item_last_ff <= is_last;
         frame_end_ff <= is_last && cmd.frame_end;
         overflow_ff  <= (slot == SLOT_OVERFLOW);
         length_ff    <= (is_last && cmd.frame_end) ? cmd.len : '0;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_item_last      = item_last_ff;
   assign rsp_frame_end      = frame_end_ff;
   assign rsp_overflow       = overflow_ff;
   assign rsp_encoded_length = length_ff;

endmodule

// File: rtl/rgb565_qoi_encoder_unit.sv
`timescale 1ns / 1ps
// Streaming QOI-style encoder for RGB565 pixels, one result beat per encoded byte.
// The front stage takes one pixel per cycle while the command queue is not full:
// it looks the color up in a 64x16 index memory, tracks the run, byte count and
// capacity, and queues one command for each pixel that produces bytes into a
// 4-entry command queue. The back stage turns each command into bytes at one beat
// per cycle while the receiver keeps popping. A pixel produces 3 bytes for a raw
// color, 1 for an index hit, 0 while a run grows, plus 8 header bytes at frame
// start and 1 or 3 bytes when a run is flushed. Index entries carry valid bits
// that are all cleared at once at frame start; there is no clearing pass after
// reset.
module rgb565_qoi_encoder_unit import qoe_pkg::*; #(
   parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [15:0]      req_pixel_color,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_item_last,
   output logic             rsp_frame_end,
   output logic             rsp_overflow,
   output logic [31:0]      rsp_encoded_length,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   logic [15:0]      width_ff, height_ff;
   logic [LEN_W-1:0] capacity_ff, total_ff;

   logic    cmd_push, cmd_full, cmd_valid, cmd_pop;
   cmd_type cmd_wdata, cmd_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 16'd1;
         height_ff   <= 16'd1;
         capacity_ff <= 32'd65536;
         total_ff    <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH: begin
               width_ff <= csr_wdata[15:0];
               total_ff <= {16'b0, csr_wdata[15:0]} * {16'b0, height_ff};
            end
            CSR_HEIGHT: begin
               height_ff <= csr_wdata[15:0];
               total_ff  <= {16'b0, width_ff} * {16'b0, csr_wdata[15:0]};
            end
            CSR_CAPACITY: begin
               capacity_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   qoe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_color (req_pixel_color),
      .capacity        (capacity_ff),
      .total           (total_ff),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_wdata),
      .cmd_full        (cmd_full)
   );

   qoe_cmdq #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .valid (cmd_valid),
      .rdata (cmd_rdata)
   );

   qoe_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd_rdata),
      .cmd_pop            (cmd_pop),
      .image_width        (width_ff),
      .image_height       (height_ff),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_item_last      (rsp_item_last),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_overflow       (rsp_overflow),
      .rsp_encoded_length (rsp_encoded_length)
   );

`ifndef NO_ASSERTIONS
   a_cmdq_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command queue written while full");

   a_cmdq_no_underrun: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command queue read while empty");

   a_overflow_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_overflow) |->
         (rsp_out_byte == 8'd0 && !rsp_frame_end && rsp_item_last))
      else $error("overflow beat carries data or frame end");

   a_frame_end_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> (rsp_item_last && !rsp_overflow))
      else $error("frame end not on the last beat of a pixel");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import qoe_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        item_last;
      logic        frame_end;
      logic        overflow;
      logic [31:0] encoded_length;
   } enc_beat_t;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e   kind;
      logic [1:0]  index;
      logic [31:0] value;
      logic        typed;
      enc_beat_t   want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [15:0] req_pixel_color = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_item_last;
   logic        rsp_frame_end;
   logic        rsp_overflow;
   logic [31:0] rsp_encoded_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rgb565_qoi_encoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_pixel_color    (req_pixel_color),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_item_last      (rsp_item_last),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_overflow       (rsp_overflow),
      .rsp_encoded_length (rsp_encoded_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   // encoder shadow state
   logic [15:0]       cfg_width = 16'd1;
   logic [15:0]       cfg_height = 16'd1;
   logic [31:0]       cfg_capacity = 32'd65536;
   logic [15:0]       last_color = '0;
   logic [15:0]       color_table [INDEX_ENTRIES];
   logic [RUN_W-1:0]  run_len = '0;
   logic [31:0]       frame_pixels = '0;
   logic [31:0]       frame_bytes = '0;
   logic              frame_lost = 1'b0;

   enc_beat_t pixel_beats[$];
   enc_beat_t expected_bytes[$];
   stim_row_t plan[$];

   int sender_idle_pct = 12;
   int receiver_idle_pct = 86;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int error_count = 0;
   int beats_checked = 0;
   int pixels_sent = 0;
   int frames_closed = 0;
   int overflows = 0;
   int long_runs = 0;
   int index_hits = 0;

   function automatic logic [HASH_W-1:0] color_slot(input logic [15:0] c);
      logic [15:0] mix;
      mix = c ^ (c >> 5) ^ (c >> 11);
      return mix[HASH_W-1:0];
   endfunction

   function automatic void add_beat(input logic [7:0] b, input logic ovf);
      enc_beat_t x;
      x.out_byte = b;
      x.item_last = 1'b0;
      x.frame_end = 1'b0;
      x.overflow = ovf;
      x.encoded_length = '0;
      pixel_beats.push_back(x);
   endfunction

   // bytes[7:0] goes out first
   function automatic bit emit_token(input logic [63:0] bytes, input int count);
      if ({32'd0, frame_bytes} + 64'(count) > {32'd0, cfg_capacity}) begin
         add_beat(8'h00, 1'b1);
         frame_lost = 1'b1;
         overflows++;
         return 1'b0;
      end
      for (int i = 0; i < count; i++)
         add_beat(bytes[8*i +: 8], 1'b0);
      frame_bytes += 32'(count);
      return 1'b1;
   endfunction

   function automatic bit flush_run();
      logic [15:0] r;
      bit ok;
      if (run_len == 0)
         return 1'b1;
      r = 16'(run_len - 1);
      if (run_len <= SHORT_RUN_MAX) begin
         ok = emit_token({56'd0, OP_RUN | {2'b00, r[5:0]}}, 1);
      end else begin
         long_runs++;
         ok = emit_token({40'd0, r[15:8], r[7:0], OP_LONG_RUN}, 3);
      end
      run_len = '0;
      return ok;
   endfunction

   function automatic void predict_pixel(input logic [15:0] color);
      longint            frame_total;
      bit                is_last;
      logic [HASH_W-1:0] slot;
      enc_beat_t         tail;
      frame_total = longint'(cfg_width) * longint'(cfg_height);
      is_last = (longint'(frame_pixels) + 1) >= frame_total;
      pixel_beats.delete();
      if (frame_pixels == 0) begin
         last_color = '0;
         foreach (color_table[i])
            color_table[i] = '0;
         run_len = '0;
         frame_bytes = '0;
         frame_lost = 1'b0;
         void'(emit_token({cfg_height[15:8], cfg_height[7:0], cfg_width[15:8], cfg_width[7:0],
                           MAGIC3, MAGIC2, MAGIC1, MAGIC0}, 8));
      end
      if (!frame_lost) begin
         if (color == last_color) begin
            run_len++;
            if (run_len >= RUN_CAP || is_last)
               void'(flush_run());
         end else if (flush_run()) begin
            slot = color_slot(color);
            if (color_table[slot] == color) begin
               index_hits++;
               void'(emit_token({56'd0, 8'(slot)}, 1));
            end else if (emit_token({40'd0, color[15:8], color[7:0], OP_RAW}, 3)) begin
               color_table[slot] = color;
            end
            last_color = color;
         end
      end
      if (pixel_beats.size() > 0) begin
         tail = pixel_beats[pixel_beats.size()-1];
         tail.item_last = 1'b1;
         if (is_last && !frame_lost) begin
            tail.frame_end = 1'b1;
            tail.encoded_length = frame_bytes;
            frames_closed++;
         end
         pixel_beats[pixel_beats.size()-1] = tail;
      end
      frame_pixels = is_last ? 32'd0 : frame_pixels + 1;
      foreach (pixel_beats[k])
         expected_bytes.push_back(pixel_beats[k]);
   endfunction

   function automatic void log_error(input string what, input enc_beat_t want,
                                     input enc_beat_t seen);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t %s: expected byte %02h last %0b end %0b ovf %0b len %0d", $time, what,
                  want.out_byte, want.item_last, want.frame_end, want.overflow,
                  want.encoded_length);
         $display("%0t %s: actual   byte %02h last %0b end %0b ovf %0b len %0d", $time, what,
                  seen.out_byte, seen.item_last, seen.frame_end, seen.overflow,
                  seen.encoded_length);
      end
   endfunction

   function automatic void add_pixel_row(input logic [15:0] c);
      stim_row_t row;
      row = '0;
      row.kind = ROW_PIXEL;
      row.value = 32'(c);
      plan.push_back(row);
   endfunction

   function automatic void add_checked_row(input logic [15:0] c, input logic [7:0] b,
                                           input logic fe, input logic ovf,
                                           input logic [31:0] len);
      stim_row_t row;
      row = '0;
      row.kind = ROW_PIXEL;
      row.value = 32'(c);
      row.typed = 1'b1;
      row.want.out_byte = b;
      row.want.item_last = 1'b1;
      row.want.frame_end = fe;
      row.want.overflow = ovf;
      row.want.encoded_length = len;
      plan.push_back(row);
   endfunction

   function automatic void add_csr_row(input logic [1:0] idx, input logic [31:0] v);
      stim_row_t row;
      row = '0;
      row.kind = ROW_CSR;
      row.index = idx;
      row.value = v;
      plan.push_back(row);
   endfunction

   task automatic send_pixel(input logic [15:0] color);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_color <= color;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_pixel(color);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      req_push <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_WIDTH:    cfg_width = data[15:0];
         CSR_HEIGHT:   cfg_height = data[15:0];
         CSR_CAPACITY: cfg_capacity = data;
         default: ;
      endcase
   endtask

   task automatic reconfigure(input logic [15:0] width, input logic [15:0] height,
                              input logic [31:0] capacity);
      wait_drained();
      write_csr(CSR_WIDTH, 32'(width));
      write_csr(CSR_HEIGHT, 32'(height));
      write_csr(CSR_CAPACITY, capacity);
   endtask

   task automatic encode_random_frames(input int pixel_budget);
      int          sent;
      int          frame_len;
      int          burst_left;
      logic [15:0] burst_color;
      logic [15:0] color;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] capacity;
      logic [15:0] palette [6];
      sent = 0;
      burst_left = 0;
      burst_color = '0;
      color = '0;
      width = 16'd1;
      height = 16'd1;
      for (int k = 0; k < 5; k++)
         palette[k] = 16'($urandom);
      // last palette entry shares a hash slot with the one before it
      do
         palette[5] = 16'($urandom);
      while (palette[5] == palette[4] || color_slot(palette[5]) != color_slot(palette[4]));
      while (sent < pixel_budget) begin
         if (sent == 0 || $urandom_range(1) == 0) begin
            case ($urandom_range(9))
               0: begin
                  width = 16'd1;
                  height = 16'd1;
               end
               1: begin
                  width = 16'($urandom_range(70, 140));
                  height = 16'd1;
               end
               default: begin
                  width = 16'($urandom_range(1, 8));
                  height = 16'($urandom_range(1, 6));
               end
            endcase
            if ($urandom_range(9) < 3)
               capacity = $urandom_range(0, 8 + 2 * width * height);
            else
               capacity = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd65536;
            reconfigure(width, height, capacity);
         end
         frame_len = int'(width) * int'(height);
         repeat (frame_len) begin
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               case ($urandom_range(9))
                  0, 1: begin
                     burst_color = $urandom_range(1) ? color : palette[$urandom_range(5)];
                     burst_left = ($urandom_range(5) == 0) ? $urandom_range(62, 67)
                                                           : $urandom_range(1, 4);
                  end
                  2, 3, 4: burst_color = palette[$urandom_range(5)];
                  5, 6:    burst_color = 16'($urandom);
                  7:       burst_color = 16'd1 << $urandom_range(15);
                  8:       burst_color = ~(16'd1 << $urandom_range(15));
                  default: burst_color = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
               endcase
            end
            color = burst_color;
            send_pixel(color);
            sent++;
         end
      end
   endtask

   // result side: check each beat, stall at random or on a long hold
   always @(posedge clock) begin
      enc_beat_t seen;
      enc_beat_t want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.out_byte = rsp_out_byte;
            seen.item_last = rsp_item_last;
            seen.frame_end = rsp_frame_end;
            seen.overflow = rsp_overflow;
            seen.encoded_length = rsp_encoded_length;
            beats_checked++;
            if (expected_bytes.size() == 0) begin
               log_error("beat with nothing pending", '0, seen);
            end else begin
               want = expected_bytes.pop_front();
               if (seen.out_byte !== want.out_byte || seen.item_last !== want.item_last ||
                   seen.frame_end !== want.frame_end || seen.overflow !== want.overflow ||
                   seen.encoded_length !== want.encoded_length)
                  log_error("beat mismatch", want, seen);
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d beats still pending",
                  STALL_LIMIT, expected_bytes.size());
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [15:0] run_color;

      // one-pixel frames at reset settings
      add_checked_row(16'h0000, 8'h80, 1'b1, 1'b0, 32'd9);
      add_csr_row(CSR_SPARE, 32'h0000_0707);
      add_checked_row(16'hFFFF, 8'hFF, 1'b1, 1'b0, 32'd11);
      // 4x2 frame: raw, runs, index hit
      add_csr_row(CSR_WIDTH, 32'd4);
      add_csr_row(CSR_HEIGHT, 32'd2);
      add_pixel_row(16'h1234);
      add_pixel_row(16'h1234);
      add_pixel_row(16'h1234);
      add_pixel_row(16'hABCD);
      add_pixel_row(16'h1234);
      add_pixel_row(16'h8000);
      add_pixel_row(16'h0001);
      add_pixel_row(16'h0001);
      // zero capacity drops at the header
      add_csr_row(CSR_WIDTH, 32'd1);
      add_csr_row(CSR_HEIGHT, 32'd1);
      add_csr_row(CSR_CAPACITY, 32'd0);
      add_checked_row(16'h5555, 8'h00, 1'b0, 1'b1, 32'd0);
      add_checked_row(16'h0000, 8'h00, 1'b0, 1'b1, 32'd0);
      // capacity exact fit, then overflow after the header
      add_csr_row(CSR_CAPACITY, 32'd9);
      add_checked_row(16'h0000, 8'h80, 1'b1, 1'b0, 32'd9);
      add_checked_row(16'h7777, 8'h00, 1'b0, 1'b1, 32'd0);
      // zero pixel count: every pixel closes a frame
      add_csr_row(CSR_CAPACITY, 32'hFFFF_FFFF);
      add_csr_row(CSR_WIDTH, 32'd0);
      add_checked_row(16'h00FF, 8'h00, 1'b1, 1'b0, 32'd11);
      // max dims, then shrink mid-frame so the next pixel passes the count
      add_csr_row(CSR_WIDTH, 32'h0000_FFFF);
      add_csr_row(CSR_HEIGHT, 32'h0000_FFFF);
      add_pixel_row(16'hFFFF);
      add_pixel_row(16'hFFFF);
      add_pixel_row(16'hFFFF);
      add_pixel_row(16'h0000);
      add_csr_row(CSR_WIDTH, 32'd1);
      add_csr_row(CSR_HEIGHT, 32'd1);
      add_checked_row(16'h0000, 8'h80, 1'b1, 1'b0, 32'd14);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR)
               wait_drained();
            write_csr(plan[i].index, plan[i].value);
         end else begin
            send_pixel(plan[i].value[15:0]);
            if (plan[i].typed)
               expected_bytes[expected_bytes.size()-1] = plan[i].want;
         end
      end

      // run reaching the cap, then a long run flushed by the frame's last pixel
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      reconfigure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      run_color = 16'($urandom_range(1, 16'hFFFF));
      repeat (int'(RUN_CAP) + 71) send_pixel(run_color);
      reconfigure(16'd1, 16'd1, 32'd65536);
      send_pixel(run_color);

      sender_idle_pct = 12;
      receiver_idle_pct = 86;
      encode_random_frames(100);
      wait_drained();
      sender_idle_pct = 86;
      receiver_idle_pct = 12;
      encode_random_frames(100);
      wait_drained();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      // hold the result side while raw pixels keep coming
      reconfigure(16'd48, 16'd1, 32'hFFFF_FFFF);
      hold_requests++;
      repeat (48) send_pixel(16'($urandom));
      encode_random_frames(80);
      wait_drained();

      $display("covered %0d pixels, %0d closed frames, %0d index hits, %0d long runs,",
               pixels_sent, frames_closed, index_hits, long_runs);
      $display("%0d capacity drops; %0d output beats checked, %0d errors",
               overflows, beats_checked, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/qoe_pkg.sv
rtl/qoe_ram.sv
rtl/qoe_front.sv
rtl/qoe_cmdq.sv
rtl/qoe_back.sv
rtl/rgb565_qoi_encoder_unit.sv
tb/sv/tb_top.sv
